@@ src/hqp_pkg.sv @@
`timescale 1ns / 1ps

package hqp_pkg;

    localparam int MAX_SLOTS_DEF = 32768;

    localparam int KEY_W      = 31;
    localparam int SIZE_W     = 16;
    localparam int SLOT_W     = 15;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 16'd32749;

    // word index of each register (byte address bit 2)
    localparam logic REG_TABLE_SIZE = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_HOME,
        ST_CHECK,
        ST_STEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic rd;
        logic wr;
        logic wdata;
    } ram_ctl_t;

endpackage

@@ src/hqp_mod_unit.sv @@
`timescale 1ns / 1ps

module hqp_mod_unit
    import hqp_pkg::*;
#(
    parameter int IW = 15,
    parameter int SW = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KEY_W-1:0]  dividend,
    input  logic [SW-1:0]     divisor,
    output logic              done,
    output logic [IW-1:0]     remainder
);

    localparam int TW    = IW + 1;
    localparam int CNT_W = $clog2(KEY_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [KEY_W-1:0] dvd_reg, dvd_next;
    logic [IW-1:0]    rem_reg, rem_next;

    logic [TW-1:0]    trial;
    logic [TW-1:0]    diff;
    logic             ge;

    // restoring remainder, one dividend bit per cycle, msb first
    assign trial = {rem_reg, dvd_reg[KEY_W-1]};
    assign ge    = trial >= TW'(divisor);
    assign diff  = trial - TW'(divisor);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(KEY_W - 1);
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? IW'(diff) : IW'(trial);
            dvd_next = {dvd_reg[KEY_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ src/hqp_occ_ram.sv @@
`timescale 1ns / 1ps

module hqp_occ_ram
    import hqp_pkg::*;
#(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
)
(
    input  logic          clk,
    input  ram_ctl_t      ctl,
    input  logic [AW-1:0] addr,
    output logic          rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    // single port: a write takes the cycle, otherwise a read may
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[addr] <= ctl.wdata;
        end
        else if (ctl.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/hqp_apb_regs.sv @@
`timescale 1ns / 1ps

module hqp_apb_regs
    import hqp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [SIZE_W-1:0]     table_size
);

    logic [SIZE_W-1:0] table_size_reg, table_size_next;
    logic              wr_en;
    logic              word_sel;

    assign pready   = 1'b1;
    assign word_sel = paddr[2];
    assign wr_en    = psel && penable && pwrite && pready;

    always_comb
    begin
        table_size_next = table_size_reg;
        if (wr_en && (word_sel == REG_TABLE_SIZE))
        begin
            table_size_next = pwdata[SIZE_W-1:0];
        end
    end

    always_comb
    begin
        unique case (word_sel)
            REG_TABLE_SIZE: prdata = {{(APB_DATA_W-SIZE_W){1'b0}}, table_size_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RST;
        end
        else
        begin
            table_size_reg <= table_size_next;
        end
    end

    assign table_size = table_size_reg;

endmodule

@@ src/hash_insert_quadratic_probe_core.sv @@
`timescale 1ns / 1ps

// Open-addressing hash insert with forward quadratic probing; only slot
// occupancy is kept, in a single-port RAM of MAX_SLOTS one-bit entries.
// After reset the block sweeps that RAM to empty, one slot a cycle, with
// s_tready low until the sweep ends; the size register can be written
// meanwhile. Each key then goes through the bit-serial key mod size unit
// for its home slot, and each probe costs a RAM read plus the occupancy
// check, since the RAM gives one access per cycle. A size of zero answers
// full without the divide or any probe. One key is in work at a time;
// the result register lets the next key in while a result still waits
// on m_tready.
module hash_insert_quadratic_probe_core
    import hqp_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [30:0] key, [31] zero

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [14:0] slot_index, [15] zero
    output logic                  m_tuser,   // [0] table_full

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int SW = $clog2(MAX_SLOTS + 1);
    localparam int TW = IW + 1;
    localparam int CW = (SW > SIZE_W) ? SW : SIZE_W;

    state_t state_reg, state_next;

    logic [IW-1:0]     home_reg, home_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     d_reg, d_next;
    logic [IW-1:0]     clr_addr_reg, clr_addr_next;
    logic [IW-1:0]     res_idx_reg, res_idx_next;
    logic              res_full_reg, res_full_next;
    logic              out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0] out_idx_reg, out_idx_next;
    logic              out_full_reg, out_full_next;

    logic [SIZE_W-1:0] table_size;
    logic [SW-1:0]     size_eff;
    logic              size_zero;
    logic              size_one;

    logic              div_start;
    logic              div_done;
    logic [IW-1:0]     div_rem;

    ram_ctl_t          ram_ctl;
    logic [IW-1:0]     ram_addr;
    logic              ram_rdata;

    logic [TW-1:0]     sum_i;
    logic [TW-1:0]     sum_d;
    logic [IW-1:0]     idx_step;
    logic [IW-1:0]     d_step;

    hqp_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .table_size (table_size)
    );

    hqp_mod_unit #(
        .IW (IW),
        .SW (SW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (s_tdata[KEY_W-1:0]),
        .divisor   (size_eff),
        .done      (div_done),
        .remainder (div_rem)
    );

    hqp_occ_ram #(
        .DEPTH (MAX_SLOTS),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .addr  (ram_addr),
        .rdata (ram_rdata)
    );

    // sizes above capacity saturate
    assign size_eff  = (CW'(table_size) > CW'(MAX_SLOTS)) ? SW'(MAX_SLOTS) : SW'(table_size);
    assign size_zero = (size_eff == '0);
    assign size_one  = (size_eff == SW'(1));

    // idx tracks home + i*i mod size; d tracks 2i+1 mod size, so each
    // probe step is one add with one conditional subtract
    assign sum_i    = TW'(idx_reg) + TW'(d_reg);
    assign idx_step = (sum_i >= TW'(size_eff)) ? IW'(sum_i - TW'(size_eff)) : IW'(sum_i);
    assign sum_d    = TW'(d_reg) + TW'(2);
    assign d_step   = (sum_d >= TW'(size_eff)) ? IW'(sum_d - TW'(size_eff)) : IW'(sum_d);

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        home_next      = home_reg;
        idx_next       = idx_reg;
        d_next         = d_reg;
        clr_addr_next  = clr_addr_reg;
        res_idx_next   = res_idx_reg;
        res_full_next  = res_full_reg;
        out_idx_next   = out_idx_reg;
        out_full_next  = out_full_reg;
        out_valid_next = out_valid_reg && !m_tready;
        div_start      = 1'b0;
        ram_ctl        = '0;
        ram_addr       = idx_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_ctl.wr    = 1'b1;
                ram_addr      = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == IW'(MAX_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (size_zero)
                    begin
                        res_idx_next  = '0;
                        res_full_next = 1'b1;
                        state_next    = ST_FINISH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    home_next  = div_rem;
                    idx_next   = div_rem;
                    d_next     = size_one ? '0 : IW'(1);
                    state_next = ST_HOME;
                end
            end
            ST_HOME:
            begin
                ram_ctl.rd = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!ram_rdata)
                begin
                    ram_ctl.wr    = 1'b1;
                    ram_ctl.wdata = 1'b1;
                    res_idx_next  = idx_reg;
                    res_full_next = 1'b0;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                idx_next = idx_step;
                d_next   = d_step;
                if (idx_step == home_reg)
                begin
                    // probe sequence wrapped to home: table full
                    res_idx_next  = '0;
                    res_full_next = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    ram_ctl.rd = 1'b1;
                    ram_addr   = idx_step;
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = SLOT_W'(res_idx_reg);
                    out_full_next  = res_full_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        home_reg     <= home_next;
        idx_reg      <= idx_next;
        d_reg        <= d_next;
        res_idx_reg  <= res_idx_next;
        res_full_reg <= res_full_next;
        out_idx_reg  <= out_idx_next;
        out_full_reg <= out_full_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-SLOT_W){1'b0}}, out_idx_reg};
    assign m_tuser  = out_full_reg;

`ifndef SYNTHESIS
    a_full_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[SLOT_W-1:0] == '0))
        else $error("full result carries a nonzero slot index");

    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && ram_ctl.wr) |-> (TW'(idx_reg) < TW'(size_eff)))
        else $error("slot marked outside the configured table");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("remainder ready outside the divide state");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while a key is in work");
`endif

endmodule
